// ===== hdl/hkrt_pkg.sv =====
// hkrt_pkg: shared types, codes and defaults for the hall key rapid trigger block
// used by every module under hdl; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package hkrt_pkg;

  localparam int KeysDefault          = 128;
  localparam int ScansAveragedDefault = 3;

  localparam int LevelW  = 12;
  localparam int KeyW    = 7;
  localparam int SumW    = 14;
  localparam int CfgIdxW = 3;

  localparam logic [LevelW-1:0] LevelMax = '1;

  localparam logic [LevelW-1:0] ActuationReset  = 12'd500;
  localparam logic [LevelW-1:0] TopDzReset      = 12'd60;
  localparam logic [LevelW-1:0] BottomDzReset   = 12'd880;
  localparam logic [LevelW-1:0] PressSensReset  = 12'd40;
  localparam logic [LevelW-1:0] ReleaseSensReset = 12'd40;

  localparam logic [CfgIdxW-1:0] RegActuation   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTopDz       = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBottomDz    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPressSens   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegReleaseSens = 3'd4;

  localparam logic OpCalibrate = 1'b0;
  localparam logic OpProcess   = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [LevelW-1:0] press_point;
    logic [LevelW-1:0] rest_zone;
    logic [LevelW-1:0] stroke_limit;
    logic [LevelW-1:0] press_sensitivity;
    logic [LevelW-1:0] release_sensitivity;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] idle_level;
    logic [LevelW-1:0] peak_travel;
    logic [LevelW-1:0] valley_travel;
    logic              key_down;
    logic              rapid_active;
  } key_state_t;

  typedef struct packed {
    key_state_t st;
    logic       wr;
    logic       pressed;
    logic       changed;
  } upd_t;

endpackage

`default_nettype wire

// ===== hdl/hkrt_cfg_regs.sv =====
// hkrt_cfg_regs: configuration register file written over the cfg channel
// depends on hkrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module hkrt_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [hkrt_pkg::CfgIdxW-1:0] wr_index_i,
  input  wire logic [hkrt_pkg::LevelW-1:0]  wr_data_i,
  output hkrt_pkg::cfg_t                   cfg_o
);

  hkrt_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        hkrt_pkg::RegActuation:   cfg_d.press_point         = wr_data_i;
        hkrt_pkg::RegTopDz:       cfg_d.rest_zone           = wr_data_i;
        hkrt_pkg::RegBottomDz:    cfg_d.stroke_limit        = wr_data_i;
        hkrt_pkg::RegPressSens:   cfg_d.press_sensitivity   = wr_data_i;
        hkrt_pkg::RegReleaseSens: cfg_d.release_sensitivity = wr_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_point         <= hkrt_pkg::ActuationReset;
      cfg_q.rest_zone           <= hkrt_pkg::TopDzReset;
      cfg_q.stroke_limit        <= hkrt_pkg::BottomDzReset;
      cfg_q.press_sensitivity   <= hkrt_pkg::PressSensReset;
      cfg_q.release_sensitivity <= hkrt_pkg::ReleaseSensReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/hkrt_avg.sv =====
// hkrt_avg: registered average of the scan sum, reciprocal multiply by 1/SCANS_AVERAGED
// depends on hkrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module hkrt_avg #(
  parameter int SCANS_AVERAGED = hkrt_pkg::ScansAveragedDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [hkrt_pkg::SumW-1:0] sum_i,
  output logic      [hkrt_pkg::SumW-1:0] avg_o
);

  // exact for every 14-bit sum while the divisor stays at or below 16
  localparam int Shift  = hkrt_pkg::SumW + 4;
  localparam int RecipW = Shift + 1;
  localparam int Recip  = (2 ** Shift + SCANS_AVERAGED - 1) / SCANS_AVERAGED;
  localparam int ProdW  = hkrt_pkg::SumW + RecipW;

  logic [RecipW-1:0]         recip;
  logic [ProdW-1:0]          prod;
  logic [hkrt_pkg::SumW-1:0] avg_q;

  assign recip = RecipW'(Recip);
  assign prod  = {{RecipW{1'b0}}, sum_i} * {{hkrt_pkg::SumW{1'b0}}, recip};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      avg_q <= prod[Shift +: hkrt_pkg::SumW];
    end
  end

  assign avg_o = avg_q;

endmodule

`default_nettype wire

// ===== hdl/hkrt_state_mem.sv =====
// hkrt_state_mem: per-key state memory, one write and one registered read port
// depends on hkrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module hkrt_state_mem #(
  parameter int KEYS = hkrt_pkg::KeysDefault,
  parameter int AW   = $clog2(KEYS)
) (
  input  wire logic                clk_i,
  input  wire logic                rd_en_i,
  input  wire logic [AW-1:0]       rd_addr_i,
  output hkrt_pkg::key_state_t     rd_data_o,
  input  wire logic                wr_en_i,
  input  wire logic [AW-1:0]       wr_addr_i,
  input  wire hkrt_pkg::key_state_t wr_data_i
);

  hkrt_pkg::key_state_t mem_q [KEYS];
  hkrt_pkg::key_state_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// ===== hdl/hkrt_key_update.sv =====
// hkrt_key_update: calibrate and press/release rules for one key state word
// depends on hkrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module hkrt_key_update (
  input  wire logic                      op_i,
  input  wire logic                      in_range_i,
  input  wire logic [hkrt_pkg::SumW-1:0] avg_i,
  input  wire hkrt_pkg::key_state_t      st_i,
  input  wire hkrt_pkg::cfg_t            cfg_i,
  output hkrt_pkg::upd_t                 upd_o
);

  localparam int LW = hkrt_pkg::LevelW;

  logic [hkrt_pkg::SumW-1:0] idle_ext;
  logic [hkrt_pkg::SumW-1:0] diff;
  logic [LW-1:0]             travel;
  logic [LW-1:0]             tc;
  logic [LW-1:0]             valley;
  logic [LW-1:0]             peak;
  logic [LW:0]               trig;
  hkrt_pkg::key_state_t      nx;

  assign idle_ext = {{(hkrt_pkg::SumW - LW){1'b0}}, st_i.idle_level};
  assign diff     = idle_ext - avg_i;
  assign travel   = (idle_ext > avg_i) ? diff[LW-1:0] : '0;
  assign tc       = (travel > cfg_i.stroke_limit) ? cfg_i.stroke_limit : travel;
  assign valley   = (tc < st_i.valley_travel) ? tc : st_i.valley_travel;
  assign peak     = (tc > st_i.peak_travel) ? tc : st_i.peak_travel;
  assign trig     = st_i.rapid_active ?
                    ({1'b0, valley} + {1'b0, cfg_i.press_sensitivity}) :
                    {1'b0, cfg_i.press_point};

  always_comb begin
    nx = st_i;
    if (op_i == hkrt_pkg::OpCalibrate) begin
      nx.idle_level    = (avg_i > hkrt_pkg::SumW'(hkrt_pkg::LevelMax)) ?
                         hkrt_pkg::LevelMax : avg_i[LW-1:0];
      nx.peak_travel   = '0;
      nx.valley_travel = '0;
      nx.key_down      = 1'b0;
      nx.rapid_active  = 1'b0;
    end else if (travel < cfg_i.rest_zone) begin
      nx.peak_travel   = '0;
      nx.valley_travel = '0;
      nx.key_down      = 1'b0;
      nx.rapid_active  = 1'b0;
    end else if (!st_i.key_down) begin
      nx.valley_travel = valley;
      if ({1'b0, tc} >= trig) begin
        nx.key_down     = 1'b1;
        nx.rapid_active = 1'b1;
        nx.peak_travel  = tc;
      end
    end else begin
      nx.peak_travel = peak;
      if ((peak < cfg_i.release_sensitivity) ||
          (tc <= (peak - cfg_i.release_sensitivity))) begin
        nx.key_down      = 1'b0;
        nx.valley_travel = tc;
      end
    end
  end

  always_comb begin
    upd_o.st      = nx;
    upd_o.wr      = in_range_i;
    upd_o.pressed = 1'b0;
    upd_o.changed = 1'b0;
    if (in_range_i) begin
      if (op_i == hkrt_pkg::OpCalibrate) begin
        upd_o.changed = st_i.key_down;
      end else begin
        upd_o.pressed = nx.key_down;
        upd_o.changed = nx.key_down ^ st_i.key_down;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hall_key_rapid_trigger.sv =====
// Hall key rapid trigger engine. Each item carries a key index and the sum of
// SCANS_AVERAGED ADC scans and returns one result: the key's pressed state and a
// changed flag. In the cycle an item is accepted its state word is read from the state
// memory and the scan average is formed; in the execute state, once the output register
// is free, the state is updated, written back and the result loaded into the output
// register. Each item is a single read-modify-write on the state memory, so no new item
// is taken before it is done. After reset the block clears the state memory, one key per
// cycle, and holds in_stall_o high meanwhile; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module hall_key_rapid_trigger #(
  parameter int KEYS           = hkrt_pkg::KeysDefault,
  parameter int SCANS_AVERAGED = hkrt_pkg::ScansAveragedDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         op_i,
  input  wire logic [hkrt_pkg::KeyW-1:0]    key_index_i,
  input  wire logic [hkrt_pkg::SumW-1:0]    sample_sum_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [hkrt_pkg::KeyW-1:0]    key_number_o,
  output logic                              pressed_o,
  output logic                              changed_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [hkrt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [hkrt_pkg::LevelW-1:0]  cfg_data_i
);

  localparam int AW = (KEYS > 1) ? $clog2(KEYS) : 1;

  hkrt_pkg::state_e          state_q, state_d;
  logic [AW-1:0]             clr_cnt_q, clr_cnt_d;
  logic                      op_q;
  logic [hkrt_pkg::KeyW-1:0] key_q;
  logic                      in_range_q;
  logic                      out_valid_q, out_valid_d;
  logic [hkrt_pkg::KeyW-1:0] out_key_q;
  logic                      out_pressed_q;
  logic                      out_changed_q;

  logic                      in_xfer;
  logic                      out_free;
  logic                      exec_go;
  logic                      mem_wr_en;
  logic [AW-1:0]             mem_wr_addr;
  hkrt_pkg::key_state_t      mem_wr_data;
  hkrt_pkg::key_state_t      rd_state;
  logic [hkrt_pkg::SumW-1:0] avg;
  hkrt_pkg::cfg_t            cfg;
  hkrt_pkg::upd_t            upd;

  assign cfg_ready_o = 1'b1;

  hkrt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign in_stall_o = (state_q != hkrt_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign exec_go    = (state_q == hkrt_pkg::ST_EXEC) & out_free;

  hkrt_avg #(
    .SCANS_AVERAGED (SCANS_AVERAGED)
  ) u_avg (
    .clk_i (clk_i),
    .en_i  (in_xfer),
    .sum_i (sample_sum_i),
    .avg_o (avg)
  );

  hkrt_state_mem #(
    .KEYS (KEYS),
    .AW   (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_xfer),
    .rd_addr_i (AW'(key_index_i)),
    .rd_data_o (rd_state),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  hkrt_key_update u_upd (
    .op_i       (op_q),
    .in_range_i (in_range_q),
    .avg_i      (avg),
    .st_i       (rd_state),
    .cfg_i      (cfg),
    .upd_o      (upd)
  );

  // clearing pass writes zero words, otherwise write back the updated key
  always_comb begin
    if (state_q == hkrt_pkg::ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_cnt_q;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = exec_go & upd.wr;
      mem_wr_addr = AW'(key_q);
      mem_wr_data = upd.st;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      hkrt_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(KEYS - 1)) begin
          state_d = hkrt_pkg::ST_IDLE;
        end
      end
      hkrt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = hkrt_pkg::ST_EXEC;
        end
      end
      hkrt_pkg::ST_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = hkrt_pkg::ST_IDLE;
        end
      end
      default: state_d = hkrt_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hkrt_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q       <= op_i;
      key_q      <= key_index_i;
      in_range_q <= (32'(key_index_i) < 32'(KEYS));
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      out_key_q     <= key_q;
      out_pressed_q <= upd.pressed;
      out_changed_q <= upd.changed;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_number_o = out_key_q;
  assign pressed_o    = out_pressed_q;
  assign changed_o    = out_changed_q;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == hkrt_pkg::ST_EXEC))
    else $error("accepted transfer did not enter execute");

  a_exec_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> out_valid_q)
    else $error("execute did not load the output register");

  a_no_write_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |-> ((state_q == hkrt_pkg::ST_CLEAR) || exec_go))
    else $error("state memory written outside clear or execute");

  a_out_of_range_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_go && !in_range_q) |-> (!upd.wr && !upd.pressed && !upd.changed))
    else $error("out of range key touched state or reported a press");

endmodule

`default_nettype wire

// ===== test/hkrt_checker.sv =====
// hkrt_result_checker: watches the sample, result and register channels of the hall key
// rapid trigger block, predicts every result and compares it in order; depends on hkrt_pkg
`timescale 1ns / 1ps

module hkrt_result_checker #(
  parameter int Keys          = hkrt_pkg::KeysDefault,
  parameter int ScansAveraged = hkrt_pkg::ScansAveragedDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         op_i,
  input  logic [hkrt_pkg::KeyW-1:0]    key_index_i,
  input  logic [hkrt_pkg::SumW-1:0]    sample_sum_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [hkrt_pkg::KeyW-1:0]    key_number_i,
  input  logic                         pressed_i,
  input  logic                         changed_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [hkrt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hkrt_pkg::LevelW-1:0]  cfg_data_i,
  output int                           error_count_o,
  output int                           pending_o
);
  import hkrt_pkg::*;

  localparam int MaxReported = 10;

  typedef struct packed {
    logic [KeyW-1:0] key_number;
    logic            pressed;
    logic            changed;
  } key_result_t;

  cfg_t              cfg;
  logic [LevelW-1:0] idle_level [Keys];
  logic [LevelW-1:0] peak_travel [Keys];
  logic [LevelW-1:0] valley_travel [Keys];
  logic              key_down [Keys];
  logic              rapid_active [Keys];
  key_result_t       expected_results [$];
  int                mismatches;

  function automatic void clear_key(int k);
    peak_travel[k]   = '0;
    valley_travel[k] = '0;
    key_down[k]      = 1'b0;
    rapid_active[k]  = 1'b0;
  endfunction

  function automatic key_result_t predict_key_result(logic sample_op, logic [KeyW-1:0] key,
                                                     logic [SumW-1:0] sum);
    key_result_t res;
    int unsigned avg;
    int unsigned travel;
    int unsigned trig;
    logic        was_down;
    avg = sum / ScansAveraged;
    res.key_number = key;
    res.pressed    = 1'b0;
    res.changed    = 1'b0;
    if (key >= Keys) return res;
    was_down = key_down[key];
    if (sample_op == OpCalibrate) begin
      idle_level[key] = (avg > LevelMax) ? LevelMax : LevelW'(avg);
      clear_key(key);
      res.changed = was_down;
      return res;
    end
    travel = (idle_level[key] > avg) ? 32'(idle_level[key]) - avg : 0;
    if (travel < cfg.rest_zone) begin
      clear_key(key);
    end else begin
      if (travel > cfg.stroke_limit) travel = cfg.stroke_limit;
      if (!key_down[key]) begin
        if (travel < valley_travel[key]) valley_travel[key] = LevelW'(travel);
        // rapid trigger line is formed wide, no wrap
        trig = rapid_active[key] ? 32'(valley_travel[key]) + 32'(cfg.press_sensitivity)
                                 : 32'(cfg.press_point);
        if (travel >= trig) begin
          key_down[key]     = 1'b1;
          rapid_active[key] = 1'b1;
          peak_travel[key]  = LevelW'(travel);
        end
      end else begin
        if (travel > peak_travel[key]) peak_travel[key] = LevelW'(travel);
        if (peak_travel[key] < cfg.release_sensitivity ||
            travel + cfg.release_sensitivity <= peak_travel[key]) begin
          key_down[key]      = 1'b0;
          valley_travel[key] = LevelW'(travel);
        end
      end
    end
    res.pressed = key_down[key];
    res.changed = key_down[key] != was_down;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_result_t got;
    key_result_t want;
    if (!rst_ni) begin
      cfg = '{ActuationReset, TopDzReset, BottomDzReset, PressSensReset, ReleaseSensReset};
      for (int k = 0; k < Keys; k++) begin
        idle_level[k] = '0;
        clear_key(k);
      end
      expected_results.delete();
      mismatches = 0;
      error_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{key_number_i, pressed_i, changed_i};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("%0t: unexpected result key %0d pressed %0b changed %0b", $realtime,
                     got.key_number, got.pressed, got.changed);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MaxReported)
              $display("%0t: mismatch expected key %0d pressed %0b changed %0b,",
                       $realtime, want.key_number, want.pressed, want.changed,
                       " got key %0d pressed %0b changed %0b",
                       got.key_number, got.pressed, got.changed);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegActuation:   cfg.press_point         = cfg_data_i;
          RegTopDz:       cfg.rest_zone           = cfg_data_i;
          RegBottomDz:    cfg.stroke_limit        = cfg_data_i;
          RegPressSens:   cfg.press_sensitivity   = cfg_data_i;
          RegReleaseSens: cfg.release_sensitivity = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(predict_key_result(op_i, key_index_i, sample_sum_i));
      error_count_o <= mismatches;
      pending_o <= expected_results.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// testbench: drives key samples and register writes into hall_key_rapid_trigger under
// several idle and stall patterns; checking is done by hkrt_result_checker
// depends on hkrt_pkg, hall_key_rapid_trigger and hkrt_result_checker
`timescale 1ns / 1ps

module testbench;
  import hkrt_pkg::*;

  localparam int ResetCycles   = 11;
  localparam int PhaseItems    = 270;
  localparam int Phases        = 6;
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles   = 8;
  localparam int WatchdogLimit = 4000;
  localparam int KeyMax        = KeysDefault - 1;
  localparam int SumMax        = (1 << SumW) - 1;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                op          = OpCalibrate;
  logic [KeyW-1:0]     key_index   = '0;
  logic [SumW-1:0]     sample_sum  = '0;
  logic                out_stall   = 1'b0;
  logic                cfg_valid   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [LevelW-1:0]   cfg_data    = '0;
  logic                in_stall;
  logic                out_valid;
  logic [KeyW-1:0]     key_number;
  logic                pressed;
  logic                changed;
  logic                cfg_ready;
  int                  error_count;
  int                  pending_results;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_request    = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;
  int items_sent      = 0;
  int travel_span     = 1000;
  int travel_step     = 100;
  int idle_est [KeysDefault];

  wire transfer_seen = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                       (cfg_valid && cfg_ready);

  hall_key_rapid_trigger dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .key_index_i  (key_index),
    .sample_sum_i (sample_sum),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .key_number_o (key_number),
    .pressed_o    (pressed),
    .changed_o    (changed),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  hkrt_result_checker result_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .op_i          (op),
    .key_index_i   (key_index),
    .sample_sum_i  (sample_sum),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .key_number_i  (key_number),
    .pressed_i     (pressed),
    .changed_i     (changed),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .error_count_o (error_count),
    .pending_o     (pending_results)
  );

  always #1 clk = ~clk;

  // result side: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = HoldOffCycles;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || transfer_seen) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_sample(logic sample_op, logic [KeyW-1:0] key, logic [SumW-1:0] sum);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= sample_op;
    key_index  <= key;
    sample_sum <= sum;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [LevelW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all five registers, then the unused indexes, which must be ignored
  task automatic write_config(cfg_t c);
    write_reg(RegActuation, c.press_point);
    write_reg(RegTopDz, c.rest_zone);
    write_reg(RegBottomDz, c.stroke_limit);
    write_reg(RegPressSens, c.press_sensitivity);
    write_reg(RegReleaseSens, c.release_sensitivity);
    for (int i = int'(RegReleaseSens) + 1; i < (1 << CfgIdxW); i++)
      write_reg(CfgIdxW'(i), LevelW'($urandom));
    cfg_valid <= 1'b0;
    travel_span = (c.stroke_limit > 3945) ? 4095 : int'(c.stroke_limit) + 150;
    travel_step = travel_span / 6 + 1;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // calibrate now and then, then walk the key up and down its stroke
  task automatic run_key_stroke();
    int key;
    int travel;
    int level;
    int samples;
    key = $urandom_range(KeyMax);
    if (idle_est[key] == 0 || $urandom_range(3) == 0) begin
      idle_est[key] = ($urandom_range(3) == 0) ? int'(LevelMax) : $urandom_range(1500, 4095);
      send_sample(OpCalibrate, KeyW'(key),
                  SumW'(ScansAveragedDefault * idle_est[key] + $urandom_range(2)));
    end
    travel = 0;
    samples = $urandom_range(4, 30);
    repeat (samples) begin
      case ($urandom_range(7))
        0: travel = 0;
        1: travel = travel_span;
        default: travel += int'($urandom_range(2 * travel_step)) - travel_step;
      endcase
      if (travel < 0) travel = 0;
      if (travel > travel_span) travel = travel_span;
      level = (travel < idle_est[key]) ? idle_est[key] - travel : 0;
      send_sample(OpProcess, KeyW'(key),
                  SumW'(ScansAveragedDefault * level + $urandom_range(2)));
    end
  endtask

  initial begin
    cfg_t next_cfg;
    int   phase_end;
    foreach (idle_est[k]) idle_est[k] = 0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // default settings: first press, clamp, release, rapid re-press, calibrate while down
    send_sample(OpProcess, 7'd0, 14'd0);
    send_sample(OpCalibrate, 7'd0, 14'd12285);
    send_sample(OpCalibrate, 7'd127, SumW'(SumMax));
    send_sample(OpProcess, 7'd0, SumW'(3 * 4085));
    send_sample(OpProcess, 7'd0, SumW'(3 * 3595));
    send_sample(OpProcess, 7'd0, SumW'(3 * 3095));
    send_sample(OpProcess, 7'd0, SumW'(3 * 3245));
    send_sample(OpProcess, 7'd0, SumW'(3 * 3255));
    send_sample(OpProcess, 7'd0, SumW'(3 * 3225));
    send_sample(OpProcess, 7'd0, SumW'(3 * 3295));
    send_sample(OpProcess, 7'd0, SumW'(3 * 3255));
    send_sample(OpCalibrate, 7'd0, 14'd12285);
    send_sample(OpProcess, 7'd127, 14'd0);
    send_sample(OpProcess, 7'd127, SumW'(SumMax));
    send_sample(OpProcess, 7'd42, 14'h2aaa);
    send_sample(OpCalibrate, 7'd85, 14'h1555);
    wait_drained();

    // peak under release sensitivity, and a rapid trigger line past 12 bits
    next_cfg = '{12'd0, 12'd0, 12'd2000, LevelMax, LevelMax};
    write_config(next_cfg);
    send_sample(OpCalibrate, 7'd5, 14'd12285);
    send_sample(OpProcess, 7'd5, 14'd0);
    send_sample(OpProcess, 7'd5, 14'd0);
    send_sample(OpProcess, 7'd5, 14'd0);
    send_sample(OpProcess, 7'd5, 14'd12285);

    for (int phase = 0; phase < Phases; phase++) begin
      wait_drained();
      case (phase)
        0: next_cfg = '{ActuationReset, TopDzReset, BottomDzReset, PressSensReset,
                        ReleaseSensReset};
        2: next_cfg = '0;
        3: next_cfg = '1;
        default: begin
          next_cfg.rest_zone           = LevelW'($urandom_range(0, 200));
          next_cfg.stroke_limit        = LevelW'($urandom_range(400, 4095));
          next_cfg.press_point         = LevelW'($urandom_range(next_cfg.rest_zone,
                                                                next_cfg.stroke_limit));
          next_cfg.press_sensitivity   = LevelW'($urandom_range(0, 400));
          next_cfg.release_sensitivity = LevelW'($urandom_range(0, 400));
        end
      endcase
      write_config(next_cfg);
      case (phase % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin sender_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      // fill the block while results are held back
      if (phase == 0) hold_request = 1;
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        if ($urandom_range(9) == 0)
          send_sample(1'($urandom_range(1)), KeyW'($urandom_range(KeyMax)),
                      SumW'($urandom_range(SumMax)));
        else
          run_key_stroke();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && pending_results == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== hall_key_rapid_trigger.f =====
hdl/hkrt_pkg.sv
hdl/hkrt_cfg_regs.sv
hdl/hkrt_avg.sv
hdl/hkrt_state_mem.sv
hdl/hkrt_key_update.sv
hdl/hall_key_rapid_trigger.sv
test/hkrt_checker.sv
test/testbench.sv
